/* src/lpbd_pkg.sv */
// ----------------------------------------------------------------------------
// lpbd_pkg
// Shared constants, codes and controller/datapath interface types for the
// prefix-command byte decompressor.
// ----------------------------------------------------------------------------
package lpbd_pkg;

  // default sizes
  localparam int DEF_WINDOW   = 65536;
  localparam int DEF_MAX_COPY = 512;

  // command byte class boundaries
  localparam logic [7:0] CMD_LIT  = 8'h80;
  localparam logic [7:0] CMD_SEED = 8'h90;
  localparam logic [7:0] CMD_LSH  = 8'hA0;
  localparam logic [7:0] CMD_OSH  = 8'hC0;

  // field masks
  localparam logic [7:0] MASK_OSH = 8'h3F;
  localparam logic [7:0] MASK_LSH = 8'h1F;
  localparam logic [7:0] MASK_LOW = 8'h0F;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIST = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic take;        // input transaction accepted
    logic setup;       // compute copy source, load first chunk
    logic rd_issue;    // issue one history read
    logic emit_chunk;  // send packed copy chunk
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic copy_go;     // current input byte starts a valid copy
    logic can_emit;    // output register free this cycle
    logic last_issue;  // last read of the current chunk
    logic copy_end;    // current chunk finishes the copy
  } dp_stat_t;

endpackage

/* src/lpbd_ram.sv */
// ----------------------------------------------------------------------------
// lpbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lpbd_ctrl.sv */
// ----------------------------------------------------------------------------
// lpbd_ctrl
// Sequencer: accepts input bytes and walks copy commands chunk by chunk.
// ----------------------------------------------------------------------------
module lpbd_ctrl
  import lpbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;

  // input accepted only when idle and a result slot is free
  assign in_stall = !((state == S_IDLE) && stat.can_emit);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.take       = (state == S_IDLE) && stat.can_emit && in_valid;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && stat.copy_go) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.rd_issue = 1'b1;
        if (stat.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.can_emit) begin
          cmd.emit_chunk = 1'b1;
          state_next     = stat.copy_end ? S_IDLE : S_RUN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* src/lpbd_dp.sv */
// ----------------------------------------------------------------------------
// lpbd_dp
// Datapath: command decode, accumulators, history memory, copy packing and
// the output register.
// ----------------------------------------------------------------------------
module lpbd_dp
  import lpbd_pkg::*;
#(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int MAX_COPY = DEF_MAX_COPY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [7:0]  in_byte,
  input  logic        out_stall,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [63:0] out_bytes,
  output logic [3:0]  lane_count,
  output logic        last_of_run,
  output logic [31:0] out_total,
  output logic        done_res,
  output logic [1:0]  status
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(MAX_COPY + 1);
  localparam logic [AW:0]   WIN      = (AW+1)'(WINDOW);
  localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW - 1);

  // architectural state
  logic [31:0] out_limit, length_acc, offset_acc, prefix_count;
  logic [31:0] literals_left, out_position;
  logic        stopped, error_seen;
  logic [AW-1:0] wr_ptr, src;
  logic [AW:0]   fill, cp_dist;

  // copy engine
  logic [CW-1:0] rem;
  logic [3:0]    chunk;
  logic [2:0]    iss_cnt, wl;
  logic [63:0]   word;
  logic          wr_pend, fwd_hit;
  logic [7:0]    fwd_data, ram_q, rd_byte;

  // decode
  logic        blocked, is_lit, is_copy, limit_now, limit_inc;
  logic [31:0] pos_inc;
  logic [35:0] x_dist, len_sum;
  logic        dist_bad, len_bad, bad_copy;
  logic [36:0] lit_cnt;
  logic        lit_push, push, emit_item, emit;
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [CW-1:0] rem_after;
  logic [AW:0]   wr_ext, src_calc;

  assign blocked   = stopped || error_seen;
  assign is_lit    = (literals_left != 32'd0);
  assign is_copy   = (in_byte < CMD_LIT);
  assign limit_now = (out_limit != 32'd0) && (out_position >= out_limit);
  assign pos_inc   = out_position + 32'd1;
  assign limit_inc = (out_limit != 32'd0) && (pos_inc >= out_limit);

  // copy checks: distance > fill  <=>  distance-1 >= fill
  assign x_dist   = {offset_acc, in_byte[3:0]};
  assign dist_bad = x_dist >= 36'(fill);
  assign len_sum  = 36'({length_acc, in_byte[6:4]}) + 36'(prefix_count) + 36'd2;
  assign len_bad  = len_sum > 36'(MAX_COPY);
  assign bad_copy = dist_bad || len_bad;
  assign lit_cnt  = {1'b0, length_acc, in_byte[3:0]} + 37'd1;

  assign lit_push  = cmd.take && !blocked && is_lit;
  assign push      = lit_push || wr_pend;
  assign emit_item = cmd.take && !blocked && (is_lit || limit_now || (is_copy && bad_copy));
  assign emit      = emit_item || cmd.emit_chunk;

  // read data with bypass for a byte written in the same cycle it was read
  assign rd_byte   = fwd_hit ? fwd_data : ram_q;
  assign mem_we    = push;
  assign mem_wdata = lit_push ? in_byte : rd_byte;

  assign rem_after = rem - CW'(chunk);
  assign wr_ext    = {1'b0, wr_ptr};
  assign src_calc  = (wr_ext >= cp_dist) ? (wr_ext - cp_dist) : (wr_ext + WIN - cp_dist);

  // status to controller
  assign stat.copy_go    = !blocked && !is_lit && !limit_now && is_copy && !bad_copy;
  assign stat.can_emit   = !out_valid || !out_stall;
  assign stat.last_issue = (iss_cnt == 3'(chunk - 4'd1));
  assign stat.copy_end   = (rem == CW'(chunk));

  // history memory
  lpbd_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (mem_wdata),
    .re    (cmd.rd_issue),
    .raddr (src),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit     <= '0;
      length_acc    <= '0;
      offset_acc    <= '0;
      prefix_count  <= '0;
      literals_left <= '0;
      out_position  <= '0;
      stopped       <= 1'b0;
      error_seen    <= 1'b0;
      wr_ptr        <= '0;
      fill          <= '0;
      wr_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) out_limit <= cfg_wr_data;
      wr_pend <= cmd.rd_issue;

      // history write pointer and output position
      if (push) begin
        wr_ptr       <= (wr_ptr == WIN_LAST) ? '0 : wr_ptr + AW'(1);
        out_position <= pos_inc;
        if (fill != WIN) fill <= fill + (AW+1)'(1);
      end

      // item decode
      if (cmd.take && !blocked) begin
        priority if (is_lit) begin
          literals_left <= literals_left - 32'd1;
          if (literals_left == 32'd1 && limit_inc) stopped <= 1'b1;
        end else if (limit_now) begin
          stopped <= 1'b1;
        end else if (is_copy) begin
          length_acc   <= '0;
          offset_acc   <= '0;
          prefix_count <= '0;
          if (bad_copy) error_seen <= 1'b1;
        end else if (in_byte < CMD_SEED) begin
          literals_left <= lit_cnt[36:32] != 5'd0 ? 32'hFFFF_FFFF : lit_cnt[31:0];
          length_acc    <= '0;
          prefix_count  <= '0;
        end else begin
          prefix_count <= prefix_count + 32'd1;
          priority if (in_byte < CMD_LSH) begin
            length_acc <= {30'd0, in_byte[1:0]};
            offset_acc <= {30'd0, in_byte[3:2]};
          end else if (in_byte < CMD_OSH) begin
            length_acc <= {length_acc[26:0], in_byte[4:0] & MASK_LSH[4:0]};
          end else begin
            offset_acc <= {offset_acc[25:0], in_byte[5:0] & MASK_OSH[5:0]};
          end
        end
      end

      if (cmd.emit_chunk && stat.copy_end && limit_now) stopped <= 1'b1;

      // output register occupancy
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // copy engine payload
  always_ff @(posedge clk) begin
    if (cmd.take && stat.copy_go) begin
      cp_dist <= {1'b0, x_dist[AW-1:0]} + (AW+1)'(1);
      rem     <= len_sum[CW-1:0];
    end
    if (cmd.setup) begin
      src     <= src_calc[AW-1:0];
      chunk   <= (rem > CW'(8)) ? 4'd8 : rem[3:0];
      iss_cnt <= '0;
      wl      <= '0;
      word    <= '0;
    end
    if (cmd.rd_issue) begin
      src      <= (src == WIN_LAST) ? '0 : src + AW'(1);
      iss_cnt  <= iss_cnt + 3'd1;
      fwd_hit  <= mem_we && (wr_ptr == src);
      fwd_data <= mem_wdata;
    end
    if (wr_pend) begin
      word[wl*8 +: 8] <= rd_byte;
      wl              <= wl + 3'd1;
    end
    if (cmd.emit_chunk) begin
      rem     <= rem_after;
      chunk   <= (rem_after > CW'(8)) ? 4'd8 : rem_after[3:0];
      iss_cnt <= '0;
      wl      <= '0;
      word    <= '0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      if (cmd.emit_chunk) begin
        out_bytes   <= word;
        lane_count  <= chunk;
        last_of_run <= stat.copy_end;
        out_total   <= out_position;
        done_res    <= stat.copy_end && limit_now;
        status      <= ST_OK;
      end else if (is_lit) begin
        out_bytes   <= {56'd0, in_byte};
        lane_count  <= 4'd1;
        last_of_run <= 1'b1;
        out_total   <= pos_inc;
        done_res    <= (literals_left == 32'd1) && limit_inc;
        status      <= ST_OK;
      end else begin
        out_bytes   <= '0;
        lane_count  <= 4'd0;
        last_of_run <= 1'b1;
        out_total   <= out_position;
        done_res    <= limit_now;
        status      <= limit_now ? ST_OK : (dist_bad ? ST_DIST : ST_LEN);
      end
    end
  end

endmodule

/* src/lz_prefix_byte_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// lz_prefix_byte_decompressor_unit
// Prefix-command LZ byte-stream decompressor with packed copy output.
// ----------------------------------------------------------------------------
// Usage:
//   Compressed bytes enter on in_byte with in_valid/in_stall; results leave
//   on out_* with out_valid/out_stall. A transaction moves when valid is
//   high and stall is low. out_limit is written through cfg_wr_en and
//   cfg_wr_data while the block is idle.
//   Prefix and literal-run commands give no result; a literal or a
//   one-result command is accepted and its result appears in the output
//   register the next cycle.
//   A copy stalls the input through a setup state and then, per chunk of
//   up to eight bytes, a read state, a drain state and an emit state:
//   within a chunk the walk reads one history byte a cycle through the
//   single read port of the history RAM.
//   Input is stalled while a copy runs and while the output register holds
//   a result the receiver is stalling; a stalled receiver holds the
//   output and pauses the copy at the next chunk boundary.
//   Synchronous rst clears all accumulators, position/fill counters, limit
//   and error/stop flags; copy-engine counters and history are not cleared.
// ----------------------------------------------------------------------------
module lz_prefix_byte_decompressor_unit
  import lpbd_pkg::*;
#(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int MAX_COPY = DEF_MAX_COPY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  lane_count,
  output logic        last_of_run,
  output logic [31:0] out_total,
  output logic        done_res,
  output logic [1:0]  status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lpbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpbd_dp #(.WINDOW(WINDOW), .MAX_COPY(MAX_COPY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_byte),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_bytes   (out_bytes),
    .lane_count  (lane_count),
    .last_of_run (last_of_run),
    .out_total   (out_total),
    .done_res    (done_res),
    .status      (status)
  );

endmodule

/* sim/lpbd_stream_checker.sv */
// ----------------------------------------------------------------------------
// lpbd_stream_checker
// Watches both channels and the config port of the decompressor, decodes
// every accepted input byte in its own model of the block and compares each
// output transaction, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
module lpbd_stream_checker
  import lpbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_bytes,
  input  logic [3:0]  lane_count,
  input  logic        last_of_run,
  input  logic [31:0] out_total,
  input  logic        done_res,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  lanes;
    logic        last;
    logic [31:0] total;
    logic        done;
    logic [1:0]  st;
  } chunk_t;

  chunk_t expected_chunks[$];

  // decoder state
  logic [7:0]  hist [0:DEF_WINDOW-1];
  int unsigned wr_ptr, hist_fill;
  logic [31:0] len_acc, off_acc, pfx_cnt, lit_left, out_pos, limit_val;
  logic        stopped, err_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic bit limit_hit();
    return limit_val != 0 && out_pos >= limit_val;
  endfunction

  task automatic push_hist(input logic [7:0] v);
    hist[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1 >= DEF_WINDOW) ? 0 : wr_ptr + 1;
    if (hist_fill < DEF_WINDOW) hist_fill++;
    out_pos++;
  endtask

  task automatic expect_chunk(input logic [63:0] bytes, input logic [3:0] lanes,
                              input logic last, input logic done,
                              input logic [1:0] st);
    chunk_t c;
    c.bytes = bytes; c.lanes = lanes; c.last = last;
    c.total = out_pos; c.done = done; c.st = st;
    expected_chunks.push_back(c);
  endtask

  // one accepted compressed byte
  task automatic decode_byte(input logic [7:0] b);
    logic [63:0] len, cp_dist, cnt, word;
    int unsigned src, n, lanes;
    logic done;
    if (stopped || err_seen) return;
    // literal inside a run
    if (lit_left != 0) begin
      push_hist(b);
      lit_left--;
      done = (lit_left == 0) && limit_hit();
      if (done) stopped = 1;
      expect_chunk({56'd0, b}, 4'd1, 1'b1, done, ST_OK);
      return;
    end
    // limit already met at a command boundary
    if (limit_hit()) begin
      stopped = 1;
      expect_chunk('0, 4'd0, 1'b1, 1'b1, ST_OK);
      return;
    end
    if (b < CMD_LIT) begin
      len     = (({32'd0, len_acc} << 3) | (b >> 4)) + pfx_cnt + 2;
      cp_dist = (({32'd0, off_acc} << 4) | (b & MASK_LOW)) + 1;
      len_acc = 0; off_acc = 0; pfx_cnt = 0;
      if (cp_dist > hist_fill) begin
        err_seen = 1;
        expect_chunk('0, 4'd0, 1'b1, 1'b0, ST_DIST);
        return;
      end
      if (len > DEF_MAX_COPY) begin
        err_seen = 1;
        expect_chunk('0, 4'd0, 1'b1, 1'b0, ST_LEN);
        return;
      end
      src = (wr_ptr + DEF_WINDOW - cp_dist[31:0]) % DEF_WINDOW;
      n = len[31:0];
      while (n != 0) begin
        lanes = (n > 8) ? 8 : n;
        word = '0;
        for (int i = 0; i < lanes; i++) begin
          word[8*i +: 8] = hist[src];
          push_hist(hist[src]);
          src = (src + 1 >= DEF_WINDOW) ? 0 : src + 1;
        end
        n -= lanes;
        done = (n == 0) && limit_hit();
        if (done) stopped = 1;
        expect_chunk(word, lanes[3:0], n == 0, done, ST_OK);
      end
    end else if (b < CMD_SEED) begin
      cnt = ({32'd0, len_acc} << 4) + (b & MASK_LOW) + 1;
      lit_left = (cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt[31:0];
      len_acc = 0;
      pfx_cnt = 0;
    end else begin
      if (b < CMD_LSH) begin
        len_acc = {30'd0, b[1:0]};
        off_acc = {30'd0, b[3:2]};
      end else if (b < CMD_OSH) begin
        len_acc = {len_acc[26:0], b[4:0]};
      end else begin
        off_acc = {off_acc[25:0], b[5:0]};
      end
      pfx_cnt++;
    end
  endtask

  always @(posedge clk) begin
    chunk_t c;
    if (rst) begin
      expected_chunks.delete();
      wr_ptr = 0; hist_fill = 0;
      len_acc = 0; off_acc = 0; pfx_cnt = 0; lit_left = 0; out_pos = 0;
      limit_val = 0; stopped = 0; err_seen = 0;
    end else begin
      // compare before predicting: a result never leaves in its input's cycle
      if (out_valid && !out_stall) begin
        if (expected_chunks.size() == 0) begin
          report("unexpected output", out_bytes, '0);
        end else begin
          c = expected_chunks.pop_front();
          if (out_bytes !== c.bytes) report("out_bytes", out_bytes, c.bytes);
          if (lane_count !== c.lanes) report("lane_count", lane_count, c.lanes);
          if (last_of_run !== c.last) report("last_of_run", last_of_run, c.last);
          if (out_total !== c.total) report("out_total", out_total, c.total);
          if (done_res !== c.done) report("done_res", done_res, c.done);
          if (status !== c.st) report("status", status, c.st);
        end
      end
      if (cfg_wr_en) limit_val = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
    pending = expected_chunks.size();
  end

endmodule

/* sim/lz_prefix_byte_decompressor_unit_tb.sv */
// ----------------------------------------------------------------------------
// lz_prefix_byte_decompressor_unit_tb
// Drives directed and random compressed streams with random idle gaps on
// both sides and a long receiver hold; the stream checker predicts and
// compares. The run ends in one randomly chosen terminal case.
// ----------------------------------------------------------------------------
module lz_prefix_byte_decompressor_unit_tb;
  import lpbd_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic        clk, rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid, in_stall;
  logic [7:0]  in_byte;
  logic        out_valid, out_stall;
  logic [63:0] out_bytes;
  logic [3:0]  lane_count;
  logic        last_of_run, done_res;
  logic [31:0] out_total;
  logic [1:0]  status;
  int          fail_count, pending;

  int          bytes_sent = 0;   // accepted input transactions
  int          gen_out    = 0;   // bytes the stream has produced so far
  int          hold_at    = 0;
  int          idle_cycles = 0;

  lz_prefix_byte_decompressor_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bytes(out_bytes), .lane_count(lane_count), .last_of_run(last_of_run),
    .out_total(out_total), .done_res(done_res), .status(status)
  );

  lpbd_stream_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bytes(out_bytes), .lane_count(lane_count), .last_of_run(last_of_run),
    .out_total(out_total), .done_res(done_res), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold while the sender keeps offering
  initial begin
    bit held;
    int g;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && hold_at != 0 && bytes_sent >= hold_at) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        g = pick_gap();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // one input transaction; valid stays high if no gap follows
  task automatic send_byte(input logic [7:0] b);
    int g;
    in_byte  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drop valid, drain expected results, let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic literal_run(input int n);
    send_byte(CMD_LIT | 8'(n - 1));
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    gen_out += n;
  endtask

  // well-formed copy with a distance inside the written history
  task automatic copy_token();
    int maxd, d, q, pc, la, hi;
    bit use_len;
    maxd = (gen_out < DEF_WINDOW) ? gen_out : DEF_WINDOW;
    if ($urandom_range(0, 9) < 7) d = $urandom_range(1, (maxd < 64) ? maxd : 64);
    else d = $urandom_range(1, (maxd < 3000) ? maxd : 3000);
    q = (d - 1) >> 4;
    use_len = ($urandom_range(0, 3) == 0);
    pc = 0;
    la = 0;
    if (q < 4 && $urandom_range(0, 1)) begin
      // seed carries the offset directly
      if (!use_len) la = $urandom_range(0, 3);
      send_byte(CMD_SEED | 8'(q << 2) | 8'(la));
      pc = 1;
    end else if (q == 0 && !use_len && $urandom_range(0, 1)) begin
      // bare copy command
    end else begin
      send_byte(CMD_SEED);
      pc = 1;
      if (q >= 64) begin
        send_byte(CMD_OSH | 8'((q >> 6) & MASK_OSH));
        pc++;
      end
      if (q != 0) begin
        send_byte(CMD_OSH | 8'(q & MASK_OSH));
        pc++;
      end
    end
    if (use_len) begin
      la = $urandom_range(0, 31);
      send_byte(CMD_LSH | 8'(la));
      pc++;
    end
    hi = $urandom_range(0, 7);
    send_byte(8'(hi << 4) | 8'((d - 1) & MASK_LOW));
    gen_out += ((la << 3) | hi) + pc + 2;
  endtask

  // malformed prefixes that leave the stream decodable
  task automatic noise_token();
    int x, lo;
    if ($urandom_range(0, 1)) begin
      send_byte(CMD_OSH | 8'($urandom_range(0, 63)));
      send_byte(CMD_SEED);
      literal_run($urandom_range(1, 4));
    end else begin
      x = $urandom_range(0, 3);
      lo = $urandom_range(0, 15);
      send_byte(CMD_LSH | 8'(x));
      send_byte(CMD_LIT | 8'(lo));
      repeat (x * 16 + lo + 1) send_byte(8'($urandom_range(0, 255)));
      gen_out += x * 16 + lo + 1;
    end
  endtask

  task automatic random_part(input int count);
    int r, stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) literal_run(($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8));
      else if (r < 90) copy_token();
      else noise_token();
    end
  endtask

  initial begin
    int ending;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(32'd0);

    // directed: literal extremes, short and chunked copies, seeds and shifts
    send_byte(CMD_LIT | 8'hF);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h55); send_byte(8'hAA);
    repeat (12) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(CMD_SEED); send_byte(CMD_OSH); send_byte(CMD_LSH); send_byte(8'h7F);
    send_byte(CMD_SEED | 8'h4); send_byte(8'h75);
    send_byte(CMD_SEED | 8'hB); send_byte(8'h00);
    send_byte(CMD_LIT); send_byte(8'h5A);
    gen_out = 77;
    wait_idle();

    write_limit(32'hFFFF_FFFF);
    hold_at = bytes_sent + 20;
    random_part(30);
    wait_idle();
    write_limit($urandom_range(32'h0001_0000, 32'hFFFF_FFFE));
    random_part(30);
    wait_idle();

    // terminal case: everything after it is ignored until reset
    ending = $urandom_range(0, 5);
    case (ending)
      0: begin  // distance beyond history
        send_byte(CMD_SEED);
        repeat (3) send_byte(8'hFF);
        send_byte(8'h0F);
      end
      1: begin  // copy longer than the maximum
        send_byte(CMD_SEED); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'h00);
      end
      2: begin  // limit reached by a copy
        write_limit(32'(gen_out + 5));
        send_byte(8'h70);
      end
      3: begin  // limit lowered below current size
        write_limit(32'd1);
        send_byte(8'($urandom_range(0, 255)));
      end
      4: begin  // saturated literal count
        repeat (7) send_byte(8'hBF);
        send_byte(CMD_LIT | 8'hF);
        repeat (20) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin  // limit reached inside a literal run, stop at its end
        write_limit(32'(gen_out + 2));
        literal_run(4);
      end
    endcase
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (30) @(posedge clk);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
